// ===== src/ftra_pkg.sv =====
// Shared types and constants for the frame tagged ring allocator.
package ftra_pkg;

  localparam int REGION_DEPTH = 16;
  localparam int IDX_W = $clog2(REGION_DEPTH);
  localparam int CNT_W = $clog2(REGION_DEPTH + 1);

  localparam logic [31:0] CAPACITY_RESET = 32'(128 * 1024 * 4);

  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_TRIM = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_RESTART = 2'd1;
  localparam logic [1:0] STATUS_OVERSIZE = 2'd2;
  localparam logic [1:0] STATUS_FULL = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [31:0] byte_count;
    logic [63:0] frame_number;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [4:0]  regions_in_use;
  } rsp_word_t;

  typedef struct packed {
    logic [31:0] start;
    logic [63:0] frame;
  } region_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== src/ftra_cell.sv =====
// One region cell of the queue chain: loads a new region or takes its neighbor's.
module ftra_cell (
  input  logic                 clk,
  input  ftra_pkg::cell_ctrl_t ctrl,
  input  ftra_pkg::region_t    neighbor,
  input  ftra_pkg::region_t    load_data,
  output ftra_pkg::region_t    q
);

  ftra_pkg::region_t region;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      region <= neighbor;
    end else if (ctrl.load) begin
      region <= load_data;
    end
  end

  assign q = region;

endmodule

// ===== src/frame_tagged_ring_allocator.sv =====
// Top level of the frame tagged ring allocator: control, newest region and cell chain.
//
// Requests arrive on the req channel (valid/ready) as one word holding an
// operation, a byte count and a frame number. Each request yields exactly one
// word on the rsp channel: a status, the granted offset and the number of
// live regions afterwards. The ring size is set by cfg_write_en/cfg_write_data
// and may only be changed while no request is in flight.
//
// The live regions sit in a chain of cells ordered oldest first; the oldest
// is always in cell 0, so a trim shifts the chain by one cell per cycle.
// An allocate forms the end-of-newest sum in ST_CALC, then makes the fit
// decision in ST_DEC and registers its result once the output register is
// free. A trim retires its regions from cell 0 in ST_TRIM, then registers
// its result after the final compare, again once the output register is
// free. The next request is accepted only on the return to ST_IDLE.
//
// Reset empties the queue and sets the ring size to 524288 bytes; no
// clearing pass is needed. A finished result waits in the output register
// while the next request is accepted; if the receiver is still stalling when
// that request completes, the block holds there until the word is taken.
module frame_tagged_ring_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ftra_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ftra_pkg::rsp_word_t rsp,
  input  logic                cfg_write_en,
  input  logic [31:0]         cfg_write_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DEC = 2'd2;
  localparam logic [1:0] ST_TRIM = 2'd3;

  logic [1:0] state;
  logic [ftra_pkg::CNT_W-1:0] count;
  logic [31:0] capacity;

  logic [31:0] need;
  logic [63:0] frame;
  logic [32:0] after_end;
  logic [31:0] newest_start;
  logic [31:0] newest_len;
  logic [63:0] newest_frame;

  ftra_pkg::region_t cell_q [ftra_pkg::REGION_DEPTH];
  ftra_pkg::region_t new_region;
  ftra_pkg::region_t oldest;

  logic [33:0] end_sum;
  logic [33:0] oldest_w;
  logic [33:0] cap_w;
  logic [33:0] after_w;
  logic empty;
  logic found;
  logic at_after;
  logic oversize;
  logic restart;
  logic extend;
  logic full;
  logic push;
  logic [31:0] where_off;
  logic out_free;
  logic dec_fire;
  logic push_en;
  logic pop;
  logic trim_done;
  logic [ftra_pkg::IDX_W-1:0] wr_idx;
  logic [ftra_pkg::CNT_W-1:0] count_base;

  assign oldest = cell_q[0];
  assign out_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  // Fit test: all sums are kept wide so nothing wraps against the capacity.
  always_comb begin
    end_sum = {1'b0, after_end} + {2'b00, need};
    oldest_w = {2'b00, oldest.start};
    cap_w = {2'b00, capacity};
    after_w = {1'b0, after_end};
    empty = (count == '0);
    found = 1'b0;
    at_after = 1'b0;
    if (empty) begin
      found = (need <= capacity);
    end else if (oldest_w < after_w) begin
      if (end_sum < cap_w) begin
        found = 1'b1;
        at_after = 1'b1;
      end else if (need < oldest.start) begin
        found = 1'b1;
      end
    end else if (end_sum <= oldest_w) begin
      found = 1'b1;
      at_after = 1'b1;
    end
    oversize = !found && (need > capacity);
    restart = !found && !oversize;
    extend = found && !empty && at_after && (frame == newest_frame);
    full = found && !extend && (count == ftra_pkg::CNT_W'(ftra_pkg::REGION_DEPTH));
    push = !oversize && !extend && !full;
    where_off = (found && at_after) ? after_end[31:0] : 32'd0;
    count_base = restart ? '0 : count;
    wr_idx = count_base[ftra_pkg::IDX_W-1:0];
  end

  assign dec_fire = (state == ST_DEC) && out_free;
  assign push_en = dec_fire && push;
  assign pop = (state == ST_TRIM) && !empty && (oldest.frame <= frame);
  assign trim_done = (state == ST_TRIM) && !pop && out_free;

  assign new_region.start = where_off;
  assign new_region.frame = frame;

  for (genvar i = 0; i < ftra_pkg::REGION_DEPTH; i++) begin : g_cell
    ftra_pkg::cell_ctrl_t ctrl;
    ftra_pkg::region_t neighbor;

    assign ctrl.shift = pop;
    assign ctrl.load = push_en && (wr_idx == ftra_pkg::IDX_W'(i));

    if (i == ftra_pkg::REGION_DEPTH - 1) begin : g_last
      assign neighbor = cell_q[i];
    end else begin : g_mid
      assign neighbor = cell_q[i + 1];
    end

    ftra_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .neighbor  (neighbor),
      .load_data (new_region),
      .q         (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      capacity <= ftra_pkg::CAPACITY_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (dec_fire || trim_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= (req.operation == ftra_pkg::OP_TRIM) ? ST_TRIM : ST_CALC;
          end
        end
        ST_CALC: begin
          state <= ST_DEC;
        end
        ST_DEC: begin
          if (dec_fire) begin
            state <= ST_IDLE;
            if (push) begin
              count <= count_base + ftra_pkg::CNT_W'(1);
            end
          end
        end
        ST_TRIM: begin
          if (pop) begin
            count <= count - ftra_pkg::CNT_W'(1);
          end else if (trim_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request fields, the newest region and the result word need no reset.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      need <= req.byte_count;
      frame <= req.frame_number;
    end
    if (state == ST_CALC) begin
      after_end <= {1'b0, newest_start} + {1'b0, newest_len};
    end
    if (dec_fire) begin
      if (oversize) begin
        rsp.status <= ftra_pkg::STATUS_OVERSIZE;
        rsp.offset <= 32'd0;
        rsp.regions_in_use <= 5'(count);
      end else if (extend) begin
        newest_len <= newest_len + need;
        rsp.status <= ftra_pkg::STATUS_OK;
        rsp.offset <= where_off;
        rsp.regions_in_use <= 5'(count);
      end else if (full) begin
        rsp.status <= ftra_pkg::STATUS_FULL;
        rsp.offset <= 32'd0;
        rsp.regions_in_use <= 5'(count);
      end else begin
        newest_start <= where_off;
        newest_len <= need;
        newest_frame <= frame;
        rsp.status <= restart ? ftra_pkg::STATUS_RESTART : ftra_pkg::STATUS_OK;
        rsp.offset <= where_off;
        rsp.regions_in_use <= 5'(count_base + ftra_pkg::CNT_W'(1));
      end
    end
    if (trim_done) begin
      rsp.status <= ftra_pkg::STATUS_OK;
      rsp.offset <= 32'd0;
      rsp.regions_in_use <= 5'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ftra_pkg::CNT_W'(ftra_pkg::REGION_DEPTH))
    else $error("region count above queue depth");

  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    pop |=> (count == $past(count) - ftra_pkg::CNT_W'(1)))
    else $error("trim retire did not lower the region count by one");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_DEC || $past(state) == ST_TRIM))
    else $error("result word loaded outside a finishing state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != ST_IDLE))
    else $error("accepted request did not start processing");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the frame tagged ring allocator.
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 250;

  // Tracks the live regions of the ring and the response words they imply.
  class ring_scoreboard;
    logic [31:0] capacity;
    logic [31:0] region_begin[ftra_pkg::REGION_DEPTH];
    logic [31:0] region_size[ftra_pkg::REGION_DEPTH];
    logic [63:0] region_tag[ftra_pkg::REGION_DEPTH];
    int head;
    int tail;
    int live;
    ftra_pkg::rsp_word_t due_responses[$];
    int mismatches;
    int allocates;
    int trims;
    int outcome_hits[4];
    int deepest;

    function new();
      capacity = ftra_pkg::CAPACITY_RESET;
      head = 0;
      tail = 0;
      live = 0;
      mismatches = 0;
      allocates = 0;
      trims = 0;
      deepest = 0;
      foreach (outcome_hits[i]) outcome_hits[i] = 0;
    endfunction

    function int newest();
      return (tail + ftra_pkg::REGION_DEPTH - 1) % ftra_pkg::REGION_DEPTH;
    endfunction

    // Free-space search is done 64 bits wide so sums past the ring never wrap.
    function bit find_room(logic [63:0] need, output logic [63:0] where);
      logic [63:0] cap;
      logic [63:0] after;
      logic [63:0] oldest;
      int n;
      cap = {32'd0, capacity};
      where = 64'd0;
      if (live == 0) return need <= cap;
      n = newest();
      after = {32'd0, region_begin[n]} + {32'd0, region_size[n]};
      oldest = {32'd0, region_begin[head]};
      if (oldest < after) begin
        if (after <= cap && need < cap - after) begin
          where = after;
          return 1'b1;
        end
        if (need < oldest) return 1'b1;
        return 1'b0;
      end
      if (oldest >= after + need) begin
        where = after;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [1:0] grant_bytes(logic [63:0] need, logic [63:0] frame,
                                     output logic [31:0] granted);
      logic [1:0] st;
      logic [63:0] where;
      int n;
      st = ftra_pkg::STATUS_OK;
      granted = 32'd0;
      if (!find_room(need, where)) begin
        if (need > {32'd0, capacity}) return ftra_pkg::STATUS_OVERSIZE;
        head = 0;
        tail = 0;
        live = 0;
        where = 64'd0;
        st = ftra_pkg::STATUS_RESTART;
      end
      if (live != 0) begin
        n = newest();
        if (region_tag[n] == frame &&
            {32'd0, region_begin[n]} + {32'd0, region_size[n]} == where) begin
          region_size[n] = region_size[n] + need[31:0];
          granted = where[31:0];
          return st;
        end
      end
      if (live >= ftra_pkg::REGION_DEPTH) return ftra_pkg::STATUS_FULL;
      region_begin[tail] = where[31:0];
      region_size[tail] = need[31:0];
      region_tag[tail] = frame;
      tail = (tail + 1) % ftra_pkg::REGION_DEPTH;
      live++;
      granted = where[31:0];
      return st;
    endfunction

    function void retire_rendered(logic [63:0] rendered);
      while (live != 0 && region_tag[head] <= rendered) begin
        head = (head + 1) % ftra_pkg::REGION_DEPTH;
        live--;
      end
    endfunction

    function void note_request(ftra_pkg::req_word_t w);
      ftra_pkg::rsp_word_t e;
      logic [31:0] granted;
      e.status = ftra_pkg::STATUS_OK;
      e.offset = 32'd0;
      if (w.operation == ftra_pkg::OP_ALLOCATE) begin
        e.status = grant_bytes({32'd0, w.byte_count}, w.frame_number, granted);
        e.offset = granted;
        allocates++;
      end else begin
        retire_rendered(w.frame_number);
        trims++;
      end
      e.regions_in_use = 5'(live);
      if (live > deepest) deepest = live;
      outcome_hits[e.status]++;
      due_responses.insert(due_responses.size(), e);
    endfunction

    task report(string what);
      if (mismatches < 30) $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_response(ftra_pkg::rsp_word_t got);
      ftra_pkg::rsp_word_t e;
      if (due_responses.size() == 0) begin
        report($sformatf("unexpected word status %0d offset %0d regions %0d",
                         got.status, got.offset, got.regions_in_use));
        return;
      end
      e = due_responses.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, expected %0d", got.status, e.status));
      if (got.offset !== e.offset)
        report($sformatf("offset %0d, expected %0d", got.offset, e.offset));
      if (got.regions_in_use !== e.regions_in_use)
        report($sformatf("regions_in_use %0d, expected %0d",
                         got.regions_in_use, e.regions_in_use));
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  ftra_pkg::req_word_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  ftra_pkg::rsp_word_t rsp;
  logic cfg_write_en = 1'b0;
  logic [31:0] cfg_write_data = 32'd0;

  ring_scoreboard sb;
  int cycles = 0;
  int offered = 0;
  int delivered = 0;
  int hold_cycles = 0;
  logic [63:0] frame_cursor = 64'd0;
  ftra_pkg::req_word_t directed[$];

  frame_tagged_ring_allocator dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("frame_tagged_ring_allocator: mismatch");
      $finish;
    end
  end

  // Response side: checks each taken word, stalls at random, and once holds
  // off long enough for the block to back up into its request port.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_response(rsp);
      delivered <= delivered + 1;
      if (delivered + 1 == 700) hold_cycles <= 300;
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_ready <= 1'b0;
    end else if (delivered >= 1000 && delivered < 1250) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= 36);
    end
  end

  function automatic ftra_pkg::req_word_t make_word(logic op, logic [31:0] bytes,
                                                    logic [63:0] frame);
    ftra_pkg::req_word_t w;
    w.operation = op;
    w.byte_count = bytes;
    w.frame_number = frame;
    return w;
  endfunction

  function automatic void add_directed(ftra_pkg::req_word_t w);
    directed.insert(directed.size(), w);
  endfunction

  // Mostly in-order frames with sizes well below the ring, plus some noise.
  function automatic ftra_pkg::req_word_t make_request(logic [31:0] cap, int trim_pct);
    ftra_pkg::req_word_t w;
    logic [31:0] span;
    int pick;
    span = (cap > 6) ? cap / 6 : cap;
    pick = $urandom_range(0, 99);
    w = make_word(ftra_pkg::OP_ALLOCATE, 32'd0, frame_cursor);
    if (pick < 8) begin
      w = make_word(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom});
    end else if (pick < 8 + trim_pct) begin
      w = make_word(ftra_pkg::OP_TRIM, $urandom,
                    frame_cursor - 64'($urandom_range(0, 4)));
    end else begin
      if ($urandom_range(0, 1) == 0) frame_cursor = frame_cursor + 64'd1;
      w.frame_number = frame_cursor;
      w.byte_count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cap)
                                                 : $urandom_range(0, span);
    end
    return w;
  endfunction

  task automatic sender_gap();
    if (offered >= 400 && offered < 600) return;
    if ($urandom_range(0, 99) < 36) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 36);
    end
  endtask

  // Valid stays high after acceptance; the caller lowers it for a gap.
  task automatic offer(ftra_pkg::req_word_t w);
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(w);
    offered++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.due_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.capacity = value;
  endtask

  initial begin
    logic [31:0] ring_sizes[PHASES];
    int trim_share[PHASES];
    sb = new();
    ring_sizes = '{32'd524288, 32'd4096, 32'd1, 32'hFFFF_FFFF, 32'd300,
                   32'($urandom_range(2, 32'h0010_0000)), 32'd64};
    trim_share = '{20, 8, 30, 5, 15, 20, 10};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // At the reset ring size: trim of an empty queue, oversize, zero bytes,
    // a full-ring request that forces a restart, a full queue, and extending
    // the newest region while the queue is full.
    add_directed(make_word(ftra_pkg::OP_TRIM, 32'd0, 64'd0));
    add_directed(make_word(ftra_pkg::OP_ALLOCATE, 32'hFFFF_FFFF, 64'd0));
    add_directed(make_word(ftra_pkg::OP_ALLOCATE, 32'd0, 64'd0));
    add_directed(make_word(ftra_pkg::OP_ALLOCATE, 32'd524288, 64'd0));
    add_directed(make_word(ftra_pkg::OP_TRIM, 32'hFFFF_FFFF, 64'd0));
    for (int f = 1; f <= 17; f++)
      add_directed(make_word(ftra_pkg::OP_ALLOCATE, 32'd100, 64'(f)));
    add_directed(make_word(ftra_pkg::OP_ALLOCATE, 32'd50, 64'd16));
    add_directed(make_word(ftra_pkg::OP_ALLOCATE, 32'd0, 64'd16));
    add_directed(make_word(ftra_pkg::OP_TRIM, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    frame_cursor = 64'd17;
    foreach (directed[i]) begin
      sender_gap();
      offer(directed[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(ring_sizes[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sender_gap();
        offer(make_request(ring_sizes[p], trim_share[p]));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests (%0d allocates, %0d trims) over %0d ring sizes.",
             offered, sb.allocates, sb.trims, PHASES + 1);
    $display("Outcomes: ok %0d, restart %0d, oversize %0d, full %0d; deepest queue %0d.",
             sb.outcome_hits[ftra_pkg::STATUS_OK],
             sb.outcome_hits[ftra_pkg::STATUS_RESTART],
             sb.outcome_hits[ftra_pkg::STATUS_OVERSIZE],
             sb.outcome_hits[ftra_pkg::STATUS_FULL], sb.deepest);
    if (sb.mismatches == 0 && sb.due_responses.size() == 0) begin
      $display("frame_tagged_ring_allocator: match");
    end else begin
      $display("frame_tagged_ring_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ftra_pkg.sv
src/ftra_cell.sv
src/frame_tagged_ring_allocator.sv
dv/tb_top.sv
